>>> rtl/core/next_prime_search_macros.svh
// Assertion shorthands for the prime search block.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef NEXT_PRIME_SEARCH_MACROS_SVH
`define NEXT_PRIME_SEARCH_MACROS_SVH

// Same-cycle implication.
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/nps_pkg.sv
package nps_pkg;

    // Default candidate width and fixed field widths
    localparam int VALUE_BITS_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int USER_W         = 1;

    // Search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_DIV,
        S_DIV_CHK,
        S_NEXT,
        S_HIT,
        S_MISS
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // take a new start value
        logic init_test;  // divisor 3, square 9
        logic div_start;  // load the remainder unit
        logic div_step;   // one restoring step
        logic next_div;   // divisor += 2
        logic next_cand;  // candidate += 1
        logic out_hit;    // publish candidate as prime
        logic out_miss;   // publish not-found
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic lt2;        // candidate is 0 or 1
        logic lt4;        // candidate is below 4
        logic even;       // candidate is even
        logic sq_gt;      // divisor squared exceeds candidate
        logic div_last;   // last remainder step this cycle
        logic rem_zero;   // remainder is zero
        logic at_top;     // candidate is the top of the range
        logic out_busy;   // output word still waiting
    } t_stat;

endpackage

>>> rtl/core/nps_ctrl.sv
module nps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  nps_pkg::t_stat i_stat,
    output nps_pkg::t_cmd  o_cmd
);
    import nps_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.lt2)       n_state = S_NEXT;
                else if (i_stat.lt4)  n_state = S_HIT;
                else if (i_stat.even) n_state = S_NEXT;
                else                  n_state = S_TEST;
            end
            S_TEST: begin
                if (i_stat.sq_gt) n_state = S_HIT;
                else              n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_last) n_state = S_DIV_CHK;
            end
            S_DIV_CHK: begin
                if (i_stat.rem_zero) n_state = S_NEXT;
                else                 n_state = S_TEST;
            end
            S_NEXT: begin
                if (i_stat.at_top) n_state = S_MISS;
                else               n_state = S_CHECK;
            end
            S_HIT, S_MISS: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_CHECK: begin
                o_cmd.init_test = !i_stat.lt2 && !i_stat.lt4 && !i_stat.even;
            end
            S_TEST: begin
                o_cmd.div_start = !i_stat.sq_gt;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DIV_CHK: begin
                o_cmd.next_div = !i_stat.rem_zero;
            end
            S_NEXT: begin
                o_cmd.next_cand = !i_stat.at_top;
            end
            S_HIT: begin
                o_cmd.out_hit = !i_stat.out_busy;
            end
            S_MISS: begin
                o_cmd.out_miss = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/nps_dp.sv
module nps_dp #(
    parameter int VALUE_BITS = nps_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [nps_pkg::DATA_W-1:0] i_s_tdata,
    input  nps_pkg::t_cmd              i_cmd,
    output nps_pkg::t_stat             o_stat,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [nps_pkg::DATA_W-1:0] o_m_tdata,
    output logic [nps_pkg::USER_W-1:0] o_m_tuser
);
    import nps_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int SW = VB + 2;
    localparam int CW = (VB > 1) ? $clog2(VB) : 1;

    logic [VB-1:0]     r_cand, n_cand;
    logic [VB-1:0]     r_div,  n_div;
    logic [SW-1:0]     r_sq,   n_sq;
    logic [VB-1:0]     r_rem,  n_rem;
    logic [VB-1:0]     r_quo,  n_quo;
    logic [CW-1:0]     r_cnt,  n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic              r_out_found, n_out_found;

    logic [VB:0]       rem_sh;
    logic [VB:0]       rem_sub;
    logic              rem_ge;

    // One restoring step of candidate mod divisor
    always_comb begin
        rem_sh  = {r_rem, r_quo[VB-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        rem_ge  = (rem_sh >= {1'b0, r_div});
    end

    // Next values
    always_comb begin
        n_cand      = r_cand;
        n_div       = r_div;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_found = r_out_found;

        if (i_cmd.load)      n_cand = VB'(i_s_tdata);
        if (i_cmd.next_cand) n_cand = r_cand + VB'(1);

        if (i_cmd.init_test) begin
            n_div = VB'(3);
            n_sq  = SW'(9);
        end
        // (d+2)^2 = d^2 + 4d + 4
        if (i_cmd.next_div) begin
            n_div = r_div + VB'(2);
            n_sq  = r_sq + {r_div, 2'b00} + SW'(4);
        end

        if (i_cmd.div_start) begin
            n_rem = '0;
            n_quo = r_cand;
            n_cnt = '0;
        end
        if (i_cmd.div_step) begin
            n_rem = rem_ge ? rem_sub[VB-1:0] : rem_sh[VB-1:0];
            n_quo = {r_quo[VB-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
        end

        // Output register
        if (r_out_valid && i_m_tready) n_out_valid = 1'b0;
        if (i_cmd.out_hit) begin
            n_out_valid = 1'b1;
            n_out_value = DATA_W'(r_cand);
            n_out_found = 1'b1;
        end
        if (i_cmd.out_miss) begin
            n_out_valid = 1'b1;
            n_out_value = '0;
            n_out_found = 1'b0;
        end
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cand      <= n_cand;
        r_div       <= n_div;
        r_sq        <= n_sq;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_out_value <= n_out_value;
        r_out_found <= n_out_found;
    end

    // Status
    always_comb begin
        o_stat.lt2      = (r_cand[VB-1:1] == '0);
        o_stat.lt4      = (r_cand[VB-1:2] == '0);
        o_stat.even     = !r_cand[0];
        o_stat.sq_gt    = (r_sq > {2'b00, r_cand});
        o_stat.div_last = (r_cnt == CW'(VB - 1));
        o_stat.rem_zero = (r_rem == '0);
        o_stat.at_top   = &r_cand;
        o_stat.out_busy = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_value;
    assign o_m_tuser[0] = r_out_found;

endmodule

>>> rtl/core/next_prime_search.sv
// Smallest prime at or above a start value. One word in gives one word out:
// prime_value on o_m_tdata and found on o_m_tuser (0 with a zero value when
// no prime lies between the start and 2^VALUE_BITS-1; starts of 0 and 1
// answer 2). Only the low VALUE_BITS bits of the start are used. Each
// candidate is tested by trial division with odd divisors while the divisor
// squared stays at or below it; every divisor takes a square test, a pass
// through the one-bit-per-cycle remainder unit and a remainder check, and
// each candidate is first screened in a check state. A new word is taken
// only when the previous search has finished; the result sits in an output
// register, so the next start value can be taken while the result is still
// waiting.
module next_prime_search #(
    parameter int VALUE_BITS = nps_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [nps_pkg::DATA_W-1:0] i_s_tdata,   // [31:0] start_value
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [nps_pkg::DATA_W-1:0] o_m_tdata,   // [31:0] prime_value
    output logic [nps_pkg::USER_W-1:0] o_m_tuser    // [0] found
);
    import nps_pkg::*;
    `include "next_prime_search_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    // Search sequencer
    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Candidate, divisor, remainder unit, output register
    nps_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // A not-found word always carries a zero value
    `NPS_ASSERT_IMP(a_miss_zero, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0, "miss with value")
    // Output register is loaded only when free
    `NPS_ASSERT_IMP(a_load_free, cmd.out_hit || cmd.out_miss, !stat.out_busy, "result overwritten")
    // After taking a word the block is busy
    `NPS_ASSERT_NXT(a_busy, i_s_tvalid && o_s_tready, !o_s_tready, "ready while searching")
    // No remainder steps or candidate advances while idle
    `NPS_ASSERT_IMP(a_idle_quiet, o_s_tready, !cmd.div_step && !cmd.next_cand, "work while idle")

endmodule
